[rtl/core/pulse_interval_byte_decoder_top_macros.svh]
// ----------------------------------------------------------------------------
// Pulse interval byte decoder: assertion macros
// Shorthand for the clocked, reset-qualified properties used by the checker.
// ----------------------------------------------------------------------------
`ifndef PULSE_INTERVAL_BYTE_DECODER_TOP_MACROS_SVH
`define PULSE_INTERVAL_BYTE_DECODER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PIBD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PIBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/pibd_pkg.sv]
// ----------------------------------------------------------------------------
// Pulse interval byte decoder: shared package
// Field widths, fixed limits and operation codes used across the block.
// ----------------------------------------------------------------------------
package pibd_pkg;

  localparam int IV_W   = 20;  // interval and minimum-interval width
  localparam int THR_W  = 21;  // bit threshold width
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 6;   // reported fill level width
  localparam int SEEN_W = 2;
  localparam int IDX_W  = 3;

  localparam logic [IV_W-1:0]   GAP_LIMIT_US = IV_W'(999999);
  localparam logic [SEEN_W-1:0] SYNC_PULSES  = SEEN_W'(2);
  localparam logic [IDX_W-1:0]  BIT_MSB      = IDX_W'(7);

  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef struct packed {
    logic              read_valid;
    logic [BYTE_W-1:0] read_byte;
    logic              byte_done;
    logic              overflow;
    logic [CNT_W-1:0]  fifo_count;
  } result_t;

endpackage

[rtl/core/pulse_interval_byte_decoder_top.sv]
// ----------------------------------------------------------------------------
// Pulse interval byte decoder
// Latency: a result appears in the cycle after its input beat is taken.
// Throughput: one beat per cycle; in_stall rises only while a finished
// result is held by out_stall.
// Reset (rst_n low, synchronous) returns to sync mode with an empty receive
// FIFO and a minimum interval of zero; the byte store itself is not cleared.
// ----------------------------------------------------------------------------
module pulse_interval_byte_decoder_top
  import pibd_pkg::*;
#(
  parameter int FIFO_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_op,
  input  logic [IV_W-1:0]   in_interval_us,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_read_valid,
  output logic [BYTE_W-1:0] out_read_byte,
  output logic              out_byte_done,
  output logic              out_overflow,
  output logic [CNT_W-1:0]  out_fifo_count,
  // configuration
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IV_W-1:0]   cfg_min_interval_us
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW    = (PTR_W + 1 > CNT_W) ? PTR_W + 1 : CNT_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  // Decoder and FIFO control state
  logic              data_mode_r, data_mode_nxt;
  logic [SEEN_W-1:0] seen_r, seen_nxt;
  logic [THR_W-1:0]  thr_r, thr_nxt;
  logic [BYTE_W-1:0] shift_r, shift_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              skip_r, skip_nxt;
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  tail_r, tail_nxt;
  logic [IV_W-1:0]   min_iv_r;
  logic              out_valid_r, out_valid_nxt;

  result_t           res_r, res_nxt;
  logic [BYTE_W-1:0] rdata_r;
  logic [BYTE_W-1:0] mem [FIFO_DEPTH];

  logic              in_acc;
  logic              push, pop;
  logic [THR_W-1:0]  thr_sum, thr_half;
  logic [BYTE_W-1:0] shift_bit;
  logic [PTR_W-1:0]  head_inc;
  logic [CW-1:0]     used_ext;

  assign in_stall  = out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign thr_sum   = thr_r + THR_W'(in_interval_us);
  assign thr_half  = thr_sum >> 1;
  assign shift_bit = shift_r |
                     (BYTE_W'(THR_W'(in_interval_us) >= thr_r) << idx_r);
  assign head_inc  = ptr_inc(head_r);

  always_comb begin
    data_mode_nxt = data_mode_r;
    seen_nxt      = seen_r;
    thr_nxt       = thr_r;
    shift_nxt     = shift_r;
    idx_nxt       = idx_r;
    skip_nxt      = skip_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    push          = 1'b0;
    pop           = 1'b0;
    res_nxt       = '0;
    if (in_acc) begin
      if (in_op == OP_POP) begin
        if (head_r != tail_r) begin
          pop                = 1'b1;
          res_nxt.read_valid = 1'b1;
          tail_nxt           = ptr_inc(tail_r);
        end
      end else if (in_interval_us > GAP_LIMIT_US) begin
        data_mode_nxt = 1'b0;
        seen_nxt      = '0;
        thr_nxt       = '0;
      end else if (in_interval_us > min_iv_r) begin
        if (!data_mode_r) begin
          seen_nxt = seen_r + SEEN_W'(1);
          // Every second interval closes a pair: threshold is 1.5x the mean.
          if (!seen_nxt[0]) begin
            thr_nxt = thr_half + (thr_half >> 1);
          end else begin
            thr_nxt = thr_sum;
          end
          if (seen_nxt == SYNC_PULSES) begin
            data_mode_nxt = 1'b1;
            shift_nxt     = '0;
            idx_nxt       = BIT_MSB;
            skip_nxt      = 1'b0;
          end
        end else if (skip_r) begin
          skip_nxt = 1'b0;
        end else if (idx_r != '0) begin
          shift_nxt = shift_bit;
          idx_nxt   = idx_r - IDX_W'(1);
        end else begin
          res_nxt.byte_done = 1'b1;
          if (head_inc != tail_r) begin
            push     = 1'b1;
            head_nxt = head_inc;
          end else begin
            res_nxt.overflow = 1'b1;
          end
          shift_nxt = '0;
          idx_nxt   = BIT_MSB;
          skip_nxt  = 1'b1;
        end
      end
    end
    used_ext = CW'(head_nxt) - CW'(tail_nxt) +
               ((head_nxt < tail_nxt) ? CW'(FIFO_DEPTH) : '0);
    res_nxt.fifo_count = used_ext[CNT_W-1:0];
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_mode_r <= 1'b0;
      seen_r      <= '0;
      thr_r       <= '0;
      shift_r     <= '0;
      idx_r       <= BIT_MSB;
      skip_r      <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      min_iv_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      data_mode_r <= data_mode_nxt;
      seen_r      <= seen_nxt;
      thr_r       <= thr_nxt;
      shift_r     <= shift_nxt;
      idx_r       <= idx_nxt;
      skip_r      <= skip_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        min_iv_r <= cfg_min_interval_us;
      end
    end
  end

  // Result payload holds while the beat is stalled.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res_nxt;
    end
  end

  // Receive store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[head_r] <= shift_bit;
    end
    if (pop) begin
      rdata_r <= mem[tail_r];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_valid = res_r.read_valid;
  assign out_read_byte  = res_r.read_valid ? rdata_r : '0;
  assign out_byte_done  = res_r.byte_done;
  assign out_overflow   = res_r.overflow;
  assign out_fifo_count = res_r.fifo_count;

endmodule

[rtl/core/pibd_checker.sv]
// ----------------------------------------------------------------------------
// Pulse interval byte decoder: port checker
// Watches the top level's ports and flags inconsistent result beats.
// ----------------------------------------------------------------------------
`include "pulse_interval_byte_decoder_top_macros.svh"

module pibd_checker
  import pibd_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_read_valid,
  input logic [BYTE_W-1:0] out_read_byte,
  input logic              out_byte_done,
  input logic              out_overflow,
  input logic [CNT_W-1:0]  out_fifo_count
);

  // A stalled result beat stays put until it is taken.
  `PIBD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_read_byte) && $stable(out_fifo_count) && $stable(out_byte_done), "result beat changed while stalled")

  // The input side only backs off when the result register is held.
  `PIBD_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without a held result")

  // A beat is either a pop or an edge, never both.
  `PIBD_ASSERT_NOW(a_pop_xor_edge, out_valid, !(out_read_valid && out_byte_done), "pop and byte completion in one beat")

  // A dropped byte is always a completed byte.
  `PIBD_ASSERT_NOW(a_ovf_done, out_valid && out_overflow, out_byte_done, "overflow without a completed byte")

  // An empty or edge beat carries a zero byte.
  `PIBD_ASSERT_NOW(a_byte_zero, out_valid && !out_read_valid, out_read_byte == '0, "read byte not zero on an invalid read")

endmodule

bind pulse_interval_byte_decoder_top pibd_checker u_pibd_checker (.*);
